// File: src/ubrs_pkg.sv
// Package for the unaligned block request sequencer.
// Holds widths, geometry constants, codes and the front-to-back queue entry type.
// No dependencies.
package ubrs_pkg;

    // Geometry of the block store
    localparam int BLOCK_BYTES   = 512;
    localparam int BLOCKS_PER_OP = 16;
    localparam int BLK_SHIFT     = $clog2(BLOCK_BYTES);
    localparam int HLEN_W        = $clog2(BLOCK_BYTES + 1);
    localparam int MAX_CHUNK     = BLOCKS_PER_OP * BLOCK_BYTES;

    // Field widths
    localparam int CMD_W  = 2;
    localparam int POS_W  = 40;
    localparam int LEN_W  = 32;
    localparam int ADDR_W = 32;
    localparam int ACT_W  = 3;
    localparam int IDX_W  = 31;
    localparam int BCNT_W = 5;
    localparam int CIPH_W = 2;
    localparam int MOFF_W = 9;
    localparam int MLEN_W = 14;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Step bits of the pending mask; the lowest set bit is in flight
    localparam int STEPS        = 5;
    localparam int STEP_HEAD_RD = 0;
    localparam int STEP_HEAD_WR = 1;
    localparam int STEP_MID     = 2;
    localparam int STEP_TAIL_RD = 3;
    localparam int STEP_TAIL_WR = 4;

    typedef enum logic [CMD_W-1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_DONE  = 2'd2
    } t_command;

    typedef enum logic [ACT_W-1:0] {
        ACT_READ     = 3'd0,
        ACT_WRITE    = 3'd1,
        ACT_DONE_OK  = 3'd2,
        ACT_DONE_ERR = 3'd3,
        ACT_REJECT   = 3'd4
    } t_action;

    typedef enum logic [CIPH_W-1:0] {
        CIPH_NONE    = 2'd0,
        CIPH_DECRYPT = 2'd1,
        CIPH_ENCRYPT = 2'd2
    } t_cipher;

    typedef enum logic {
        KIND_START = 1'b0,
        KIND_DONE  = 1'b1
    } t_kind;

    // Classified item as it travels from front to back
    typedef struct packed {
        t_kind               kind;
        logic                is_write;
        logic                empty;
        logic                storage_error;
        logic [STEPS-1:0]    pending;
        logic [POS_W-1:0]    head_pos;
        logic [HLEN_W-1:0]   head_len;
        logic [ADDR_W-1:0]   head_addr;
        logic [POS_W-1:0]    mid_pos;
        logic [LEN_W-1:0]    mid_rem;
        logic [ADDR_W-1:0]   mid_addr;
        logic [POS_W-1:0]    tail_pos;
        logic [HLEN_W-1:0]   tail_len;
        logic [ADDR_W-1:0]   tail_addr;
    } t_entry;

endpackage

// File: src/ubrs_if.sv
// Channel interfaces for the unaligned block request sequencer.
// Depends on ubrs_pkg for field widths.
interface ubrs_req_if;
    logic                         valid;
    logic                         ready;
    logic [ubrs_pkg::CMD_W-1:0]   command;
    logic [ubrs_pkg::POS_W-1:0]   byte_position;
    logic [ubrs_pkg::LEN_W-1:0]   byte_count;
    logic [ubrs_pkg::ADDR_W-1:0]  buffer_address;
    logic                         storage_error;

    modport source (
        output valid, command, byte_position, byte_count, buffer_address, storage_error,
        input  ready
    );
    modport sink (
        input  valid, command, byte_position, byte_count, buffer_address, storage_error,
        output ready
    );
endinterface

interface ubrs_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [ubrs_pkg::ACT_W-1:0]   action;
    logic [ubrs_pkg::IDX_W-1:0]   block_index;
    logic [ubrs_pkg::BCNT_W-1:0]  block_count;
    logic [ubrs_pkg::CIPH_W-1:0]  cipher_step;
    logic [ubrs_pkg::MOFF_W-1:0]  merge_offset;
    logic [ubrs_pkg::MLEN_W-1:0]  merge_length;
    logic [ubrs_pkg::ADDR_W-1:0]  caller_address;

    modport source (
        output valid, action, block_index, block_count, cipher_step, merge_offset,
               merge_length, caller_address,
        input  ready
    );
    modport sink (
        input  valid, action, block_index, block_count, cipher_step, merge_offset,
               merge_length, caller_address,
        output ready
    );
endinterface

// File: src/ubrs_front.sv
// Front part: accepts request items and splits starts into head, middle and tail.
// Depends on ubrs_pkg and ubrs_req_if.
module ubrs_front (
    ubrs_req_if.sink              i_req,
    input  logic                  i_push_ready,
    output logic                  o_push_valid,
    output ubrs_pkg::t_entry      o_push_entry
);
    import ubrs_pkg::*;

    logic [BLK_SHIFT-1:0] w_off;
    logic [HLEN_W-1:0]    w_room;
    logic                 w_has_head;
    logic [HLEN_W-1:0]    w_head_len;
    logic [LEN_W-1:0]     w_rest;
    logic [LEN_W-1:0]     w_mid;
    logic [HLEN_W-1:0]    w_tail;
    logic [POS_W-1:0]     w_pos_mid;
    logic [ADDR_W-1:0]    w_addr_mid;
    logic                 w_is_write;
    logic                 w_is_start;

    assign i_req.ready = i_push_ready;

    always_comb begin
        w_is_write = (i_req.command == CMD_WRITE);
        w_is_start = (i_req.command == CMD_READ) || w_is_write;
        w_off      = i_req.byte_position[BLK_SHIFT-1:0];
        w_room     = HLEN_W'(BLOCK_BYTES) - HLEN_W'(w_off);
        w_has_head = (w_off != '0);
        if (!w_has_head) begin
            w_head_len = '0;
        end else if (i_req.byte_count < LEN_W'(w_room)) begin
            w_head_len = HLEN_W'(i_req.byte_count);
        end else begin
            w_head_len = w_room;
        end
        w_rest     = i_req.byte_count - LEN_W'(w_head_len);
        w_mid      = w_rest & ~LEN_W'(BLOCK_BYTES - 1);
        w_tail     = HLEN_W'(w_rest[BLK_SHIFT-1:0]);
        w_pos_mid  = i_req.byte_position + POS_W'(w_head_len);
        w_addr_mid = i_req.buffer_address + ADDR_W'(w_head_len);

        o_push_entry.kind          = w_is_start ? KIND_START : KIND_DONE;
        o_push_entry.is_write      = w_is_write;
        o_push_entry.empty         = (i_req.byte_count == '0);
        o_push_entry.storage_error = i_req.storage_error;
        o_push_entry.pending       = '0;
        if (w_has_head) begin
            o_push_entry.pending[STEP_HEAD_RD] = 1'b1;
            o_push_entry.pending[STEP_HEAD_WR] = w_is_write;
        end
        if (w_mid != '0) begin
            o_push_entry.pending[STEP_MID] = 1'b1;
        end
        if (w_tail != '0) begin
            o_push_entry.pending[STEP_TAIL_RD] = 1'b1;
            o_push_entry.pending[STEP_TAIL_WR] = w_is_write;
        end
        o_push_entry.head_pos  = i_req.byte_position;
        o_push_entry.head_len  = w_head_len;
        o_push_entry.head_addr = i_req.buffer_address;
        o_push_entry.mid_pos   = w_pos_mid;
        o_push_entry.mid_rem   = w_mid;
        o_push_entry.mid_addr  = w_addr_mid;
        o_push_entry.tail_pos  = w_pos_mid + POS_W'(w_mid);
        o_push_entry.tail_len  = w_tail;
        o_push_entry.tail_addr = w_addr_mid + w_mid;

        // Drop unused command codes: accepted, never queued
        o_push_valid = i_req.valid && (w_is_start || i_req.command == CMD_DONE);
    end

endmodule

// File: src/ubrs_queue.sv
// Short queue of classified items between front and back.
// Depends on ubrs_pkg.
module ubrs_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push_valid,
    input  ubrs_pkg::t_entry      i_push_entry,
    output logic                  o_push_ready,
    output logic                  o_pop_valid,
    output ubrs_pkg::t_entry      o_pop_entry,
    input  logic                  i_pop
);
    import ubrs_pkg::*;

    t_entry              r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QCNT_W-1:0]   r_count;
    logic                w_push;
    logic                w_pop;

    assign o_push_ready = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_entry  = r_slot[r_rd_ptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = i_pop && o_pop_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr_ptr] <= i_push_entry;
        end
    end

endmodule

// File: src/ubrs_back.sv
// Back part: holds the sequence state, steps it on each item and registers the result.
// Depends on ubrs_pkg and ubrs_rsp_if.
module ubrs_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  ubrs_pkg::t_entry      i_entry,
    output logic                  o_pop,
    ubrs_rsp_if.source            o_rsp
);
    import ubrs_pkg::*;

    function automatic logic [LEN_W-1:0] f_chunk(input logic [LEN_W-1:0] rem);
        return (rem < LEN_W'(MAX_CHUNK)) ? rem : LEN_W'(MAX_CHUNK);
    endfunction

    // Sequence state
    logic                r_busy,      n_busy;
    logic                r_is_write,  n_is_write;
    logic [STEPS-1:0]    r_pending,   n_pending;
    logic [POS_W-1:0]    r_head_pos,  n_head_pos;
    logic [HLEN_W-1:0]   r_head_len,  n_head_len;
    logic [ADDR_W-1:0]   r_head_addr, n_head_addr;
    logic [POS_W-1:0]    r_mid_pos,   n_mid_pos;
    logic [LEN_W-1:0]    r_mid_rem,   n_mid_rem;
    logic [ADDR_W-1:0]   r_mid_addr,  n_mid_addr;
    logic [POS_W-1:0]    r_tail_pos,  n_tail_pos;
    logic [HLEN_W-1:0]   r_tail_len,  n_tail_len;
    logic [ADDR_W-1:0]   r_tail_addr, n_tail_addr;

    // Output register
    logic                r_out_valid, n_out_valid;
    t_action             r_action,    w_action;
    logic [IDX_W-1:0]    r_index,     w_index;
    logic [BCNT_W-1:0]   r_bcount,    w_bcount;
    t_cipher             r_cipher,    w_cipher;
    logic [MOFF_W-1:0]   r_moff,      w_moff;
    logic [MLEN_W-1:0]   r_mlen,      w_mlen;
    logic [ADDR_W-1:0]   r_caddr,     w_caddr;

    logic                w_emit;
    logic                w_issue;
    logic [LEN_W-1:0]    w_chunk_adv;
    logic [LEN_W-1:0]    w_chunk_iss;

    assign o_pop = i_valid && (!r_out_valid || o_rsp.ready);
    assign w_chunk_adv = f_chunk(r_mid_rem);

    always_comb begin
        n_busy      = r_busy;
        n_is_write  = r_is_write;
        n_pending   = r_pending;
        n_head_pos  = r_head_pos;
        n_head_len  = r_head_len;
        n_head_addr = r_head_addr;
        n_mid_pos   = r_mid_pos;
        n_mid_rem   = r_mid_rem;
        n_mid_addr  = r_mid_addr;
        n_tail_pos  = r_tail_pos;
        n_tail_len  = r_tail_len;
        n_tail_addr = r_tail_addr;
        w_emit      = 1'b0;
        w_issue     = 1'b0;
        w_action    = ACT_DONE_OK;
        w_index     = '0;
        w_bcount    = '0;
        w_cipher    = CIPH_NONE;
        w_moff      = '0;
        w_mlen      = '0;
        w_caddr     = '0;
        w_chunk_iss = '0;

        if (o_pop) begin
            unique case (i_entry.kind)
                KIND_START: begin
                    if (r_busy) begin
                        w_emit   = 1'b1;
                        w_action = ACT_REJECT;
                    end else begin
                        n_is_write = i_entry.is_write;
                        n_pending  = '0;
                        if (i_entry.empty) begin
                            w_emit   = 1'b1;
                            w_action = ACT_DONE_OK;
                        end else begin
                            n_pending   = i_entry.pending;
                            n_head_pos  = i_entry.head_pos;
                            n_head_len  = i_entry.head_len;
                            n_head_addr = i_entry.head_addr;
                            n_mid_pos   = i_entry.mid_pos;
                            n_mid_rem   = i_entry.mid_rem;
                            n_mid_addr  = i_entry.mid_addr;
                            n_tail_pos  = i_entry.tail_pos;
                            n_tail_len  = i_entry.tail_len;
                            n_tail_addr = i_entry.tail_addr;
                            n_busy      = 1'b1;
                            w_issue     = 1'b1;
                        end
                    end
                end
                KIND_DONE: begin
                    if (r_busy) begin
                        if (i_entry.storage_error) begin
                            n_busy    = 1'b0;
                            n_pending = '0;
                            w_emit    = 1'b1;
                            w_action  = ACT_DONE_ERR;
                        end else begin
                            // Retire the step in flight
                            priority if (r_pending[STEP_HEAD_RD]) begin
                                n_pending[STEP_HEAD_RD] = 1'b0;
                            end else if (r_pending[STEP_HEAD_WR]) begin
                                n_pending[STEP_HEAD_WR] = 1'b0;
                            end else if (r_pending[STEP_MID]) begin
                                if (r_mid_rem > w_chunk_adv) begin
                                    n_mid_rem  = r_mid_rem - w_chunk_adv;
                                    n_mid_pos  = r_mid_pos + POS_W'(w_chunk_adv);
                                    n_mid_addr = r_mid_addr + w_chunk_adv;
                                end else begin
                                    n_mid_rem           = '0;
                                    n_pending[STEP_MID] = 1'b0;
                                end
                            end else if (r_pending[STEP_TAIL_RD]) begin
                                n_pending[STEP_TAIL_RD] = 1'b0;
                            end else if (r_pending[STEP_TAIL_WR]) begin
                                n_pending[STEP_TAIL_WR] = 1'b0;
                            end else begin
                                n_pending = r_pending;
                            end
                            w_issue = 1'b1;
                        end
                    end
                end
                default: begin
                    w_emit = 1'b0;
                end
            endcase
        end

        // Issue the lowest pending step of the updated state, or finish
        if (w_issue) begin
            w_emit      = 1'b1;
            w_chunk_iss = f_chunk(n_mid_rem);
            priority if (n_pending[STEP_HEAD_RD]) begin
                w_action = ACT_READ;
                w_index  = IDX_W'(n_head_pos >> BLK_SHIFT);
                w_bcount = BCNT_W'(1);
                w_cipher = CIPH_DECRYPT;
                w_moff   = MOFF_W'(n_head_pos[BLK_SHIFT-1:0]);
                w_mlen   = n_is_write ? '0 : MLEN_W'(n_head_len);
                w_caddr  = n_is_write ? '0 : n_head_addr;
            end else if (n_pending[STEP_HEAD_WR]) begin
                w_action = ACT_WRITE;
                w_index  = IDX_W'(n_head_pos >> BLK_SHIFT);
                w_bcount = BCNT_W'(1);
                w_cipher = CIPH_ENCRYPT;
                w_moff   = MOFF_W'(n_head_pos[BLK_SHIFT-1:0]);
                w_mlen   = MLEN_W'(n_head_len);
                w_caddr  = n_head_addr;
            end else if (n_pending[STEP_MID]) begin
                w_action = n_is_write ? ACT_WRITE : ACT_READ;
                w_index  = IDX_W'(n_mid_pos >> BLK_SHIFT);
                w_bcount = BCNT_W'(w_chunk_iss >> BLK_SHIFT);
                w_cipher = n_is_write ? CIPH_ENCRYPT : CIPH_DECRYPT;
                w_moff   = '0;
                w_mlen   = MLEN_W'(w_chunk_iss);
                w_caddr  = n_mid_addr;
            end else if (n_pending[STEP_TAIL_RD]) begin
                w_action = ACT_READ;
                w_index  = IDX_W'(n_tail_pos >> BLK_SHIFT);
                w_bcount = BCNT_W'(1);
                w_cipher = CIPH_DECRYPT;
                w_moff   = '0;
                w_mlen   = n_is_write ? '0 : MLEN_W'(n_tail_len);
                w_caddr  = n_is_write ? '0 : n_tail_addr;
            end else if (n_pending[STEP_TAIL_WR]) begin
                w_action = ACT_WRITE;
                w_index  = IDX_W'(n_tail_pos >> BLK_SHIFT);
                w_bcount = BCNT_W'(1);
                w_cipher = CIPH_ENCRYPT;
                w_moff   = '0;
                w_mlen   = MLEN_W'(n_tail_len);
                w_caddr  = n_tail_addr;
            end else begin
                w_action = ACT_DONE_OK;
                n_busy   = 1'b0;
            end
        end

        n_out_valid = w_emit || (r_out_valid && !o_rsp.ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_is_write  <= 1'b0;
            r_pending   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_is_write  <= n_is_write;
            r_pending   <= n_pending;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_head_pos  <= n_head_pos;
        r_head_len  <= n_head_len;
        r_head_addr <= n_head_addr;
        r_mid_pos   <= n_mid_pos;
        r_mid_rem   <= n_mid_rem;
        r_mid_addr  <= n_mid_addr;
        r_tail_pos  <= n_tail_pos;
        r_tail_len  <= n_tail_len;
        r_tail_addr <= n_tail_addr;
        if (w_emit) begin
            r_action <= w_action;
            r_index  <= w_index;
            r_bcount <= w_bcount;
            r_cipher <= w_cipher;
            r_moff   <= w_moff;
            r_mlen   <= w_mlen;
            r_caddr  <= w_caddr;
        end
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.action         = r_action;
    assign o_rsp.block_index    = r_index;
    assign o_rsp.block_count    = r_bcount;
    assign o_rsp.cipher_step    = r_cipher;
    assign o_rsp.merge_offset   = r_moff;
    assign o_rsp.merge_length   = r_mlen;
    assign o_rsp.caller_address = r_caddr;

endmodule

// File: src/unaligned_block_request_sequencer.sv
// Top level of the unaligned block request sequencer.
// Depends on ubrs_pkg, ubrs_if, ubrs_front, ubrs_queue and ubrs_back.
//
// Use of the block:
//   i_req carries one item per handshake (valid and ready high at a rising
//   edge): a read or write start with byte position, byte count and caller
//   buffer address, or a storage completion with its error flag.
//   o_rsp carries at most one result item per request item: the next storage
//   operation to run (block index, block count, cipher step and the caller
//   bytes to copy or merge), done ok, done error or a rejected start.
//   Completions while idle and unused command codes give no result.
// Timing:
//   A result is registered: an accepted item enters the front-to-back queue
//   at the accepting edge and, with the output free, the back part takes it,
//   steps the sequence and loads the output register that drives o_rsp.
//   One item is taken per cycle while the queue has room; the sequence step
//   in the back part bounds the rate at one item per cycle, and it stops
//   while a result waits on o_rsp.
// Reset (i_rst_n low, synchronous): the block goes idle with nothing pending,
//   the queue is emptied and o_rsp.valid drops.
// Stall: while o_rsp is not taken, hold the result; the back part stops
//   and the queue fills, then i_req.ready falls until a result leaves.
module unaligned_block_request_sequencer (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ubrs_req_if.sink      i_req,
    ubrs_rsp_if.source    o_rsp
);
    import ubrs_pkg::*;

    // Front to queue
    logic     w_push_valid;
    logic     w_push_ready;
    t_entry   w_push_entry;

    // Queue to back
    logic     w_pop_valid;
    logic     w_pop;
    t_entry   w_pop_entry;

    // Classify and split incoming items
    ubrs_front u_front (
        .i_req        (i_req),
        .i_push_ready (w_push_ready),
        .o_push_valid (w_push_valid),
        .o_push_entry (w_push_entry)
    );

    // Decouple the front from a stalled back part
    ubrs_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .i_push_entry (w_push_entry),
        .o_push_ready (w_push_ready),
        .o_pop_valid  (w_pop_valid),
        .o_pop_entry  (w_pop_entry),
        .i_pop        (w_pop)
    );

    // Advance the sequence and register each result
    ubrs_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_pop_valid),
        .i_entry (w_pop_entry),
        .o_pop   (w_pop),
        .o_rsp   (o_rsp)
    );

endmodule

// File: tb/sv/ubrs_op_monitor.sv
// Result monitor for the unaligned block request sequencer testbench.
// Watches both channels, predicts the storage operation for each item and compares.
// Depends on ubrs_pkg and ubrs_if.
module ubrs_op_monitor (
    input  logic i_clk,
    input  logic i_rst_n,
    ubrs_req_if  i_req,
    ubrs_rsp_if  i_rsp,
    output int   o_pending,
    output int   o_failures
);
    timeunit 1ns;
    timeprecision 1ps;
    import ubrs_pkg::*;

    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        t_action           action;
        logic [IDX_W-1:0]  block_index;
        logic [BCNT_W-1:0] block_count;
        t_cipher           cipher_step;
        logic [MOFF_W-1:0] merge_offset;
        logic [MLEN_W-1:0] merge_length;
        logic [ADDR_W-1:0] caller_address;
    } t_op;

    // Sequencer state as the predictor sees it
    logic              in_request;
    logic              write_req;
    logic [STEPS-1:0]  steps_left;
    logic [POS_W-1:0]  head_pos, mid_pos, tail_pos;
    int unsigned       head_len, tail_len;
    logic [ADDR_W-1:0] head_addr, mid_addr, tail_addr;
    logic [LEN_W-1:0]  mid_left;

    t_op expected_ops[$];
    t_op got, want;

    function automatic t_op status_op(input t_action act);
        t_op op;
        op = '0;
        op.action = act;
        return op;
    endfunction

    function automatic logic [LEN_W-1:0] chunk_size();
        return (mid_left < LEN_W'(MAX_CHUNK)) ? mid_left : LEN_W'(MAX_CHUNK);
    endfunction

    // Operation for the lowest pending step, or done when nothing is left
    function automatic t_op next_op();
        t_op op;
        logic [LEN_W-1:0] chunk;
        op = '0;
        chunk = chunk_size();
        op.block_count = BCNT_W'(1);
        if (steps_left[STEP_HEAD_RD] || steps_left[STEP_HEAD_WR]) begin
            op.block_index  = IDX_W'(head_pos / BLOCK_BYTES);
            op.merge_offset = MOFF_W'(head_pos % BLOCK_BYTES);
            if (steps_left[STEP_HEAD_RD]) begin
                op.action      = ACT_READ;
                op.cipher_step = CIPH_DECRYPT;
                if (!write_req) begin
                    op.merge_length   = MLEN_W'(head_len);
                    op.caller_address = head_addr;
                end
            end else begin
                op.action         = ACT_WRITE;
                op.cipher_step    = CIPH_ENCRYPT;
                op.merge_length   = MLEN_W'(head_len);
                op.caller_address = head_addr;
            end
        end else if (steps_left[STEP_MID]) begin
            if (write_req) begin
                op.action      = ACT_WRITE;
                op.cipher_step = CIPH_ENCRYPT;
            end else begin
                op.action      = ACT_READ;
                op.cipher_step = CIPH_DECRYPT;
            end
            op.block_index    = IDX_W'(mid_pos / BLOCK_BYTES);
            op.block_count    = BCNT_W'(chunk / BLOCK_BYTES);
            op.merge_length   = MLEN_W'(chunk);
            op.caller_address = mid_addr;
        end else if (steps_left[STEP_TAIL_RD] || steps_left[STEP_TAIL_WR]) begin
            op.block_index = IDX_W'(tail_pos / BLOCK_BYTES);
            if (steps_left[STEP_TAIL_RD]) begin
                op.action      = ACT_READ;
                op.cipher_step = CIPH_DECRYPT;
                if (!write_req) begin
                    op.merge_length   = MLEN_W'(tail_len);
                    op.caller_address = tail_addr;
                end
            end else begin
                op.action         = ACT_WRITE;
                op.cipher_step    = CIPH_ENCRYPT;
                op.merge_length   = MLEN_W'(tail_len);
                op.caller_address = tail_addr;
            end
        end else begin
            in_request = 1'b0;
            op = status_op(ACT_DONE_OK);
        end
        return op;
    endfunction

    // Split a start into head, middle and tail, then issue the first operation
    function automatic t_op open_request(input logic is_wr, input logic [POS_W-1:0] pos,
                                         input logic [LEN_W-1:0] n,
                                         input logic [ADDR_W-1:0] addr);
        int unsigned      off, h;
        logic [LEN_W-1:0] whole;
        if (in_request) return status_op(ACT_REJECT);
        write_req  = is_wr;
        steps_left = '0;
        if (n == 0) return status_op(ACT_DONE_OK);
        off = 32'(pos % BLOCK_BYTES);
        if (off != 0) begin
            h = BLOCK_BYTES - off;
            if (n < h) h = n;
            head_pos  = pos;
            head_len  = h;
            head_addr = addr;
            steps_left[STEP_HEAD_RD] = 1'b1;
            steps_left[STEP_HEAD_WR] = is_wr;
            addr = addr + h;
            pos  = pos + h;
            n    = n - h;
        end
        if (n >= BLOCK_BYTES) begin
            whole    = n - n % BLOCK_BYTES;
            mid_pos  = pos;
            mid_left = whole;
            mid_addr = addr;
            steps_left[STEP_MID] = 1'b1;
            addr = addr + whole;
            pos  = pos + whole;
            n    = n - whole;
        end
        if (n != 0) begin
            tail_pos  = pos;
            tail_len  = n;
            tail_addr = addr;
            steps_left[STEP_TAIL_RD] = 1'b1;
            steps_left[STEP_TAIL_WR] = is_wr;
        end
        in_request = 1'b1;
        return next_op();
    endfunction

    function automatic void retire_step();
        logic [LEN_W-1:0] chunk;
        chunk = chunk_size();
        if (steps_left[STEP_HEAD_RD]) begin
            steps_left[STEP_HEAD_RD] = 1'b0;
        end else if (steps_left[STEP_HEAD_WR]) begin
            steps_left[STEP_HEAD_WR] = 1'b0;
        end else if (steps_left[STEP_MID]) begin
            if (mid_left > chunk) begin
                mid_left = mid_left - chunk;
                mid_pos  = mid_pos + chunk;
                mid_addr = mid_addr + chunk;
            end else begin
                mid_left = '0;
                steps_left[STEP_MID] = 1'b0;
            end
        end else if (steps_left[STEP_TAIL_RD]) begin
            steps_left[STEP_TAIL_RD] = 1'b0;
        end else if (steps_left[STEP_TAIL_WR]) begin
            steps_left[STEP_TAIL_WR] = 1'b0;
        end
    endfunction

    // Completion: nothing while idle, done error on a failure, else the next step
    function automatic bit complete_step(input logic err, output t_op op);
        op = '0;
        if (!in_request) return 1'b0;
        if (err) begin
            in_request = 1'b0;
            steps_left = '0;
            op = status_op(ACT_DONE_ERR);
            return 1'b1;
        end
        retire_step();
        op = next_op();
        return 1'b1;
    endfunction

    function automatic string op_text(input t_op op);
        return $sformatf("act %0d blk %0h cnt %0d ciph %0d off %0d len %0d addr %0h",
                         op.action, op.block_index, op.block_count, op.cipher_step,
                         op.merge_offset, op.merge_length, op.caller_address);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_request = 1'b0;
            write_req  = 1'b0;
            steps_left = '0;
            head_pos   = '0;
            head_len   = 0;
            head_addr  = '0;
            mid_pos    = '0;
            mid_left   = '0;
            mid_addr   = '0;
            tail_pos   = '0;
            tail_len   = 0;
            tail_addr  = '0;
            expected_ops.delete();
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                got = t_op'({i_rsp.action, i_rsp.block_index, i_rsp.block_count,
                             i_rsp.cipher_step, i_rsp.merge_offset, i_rsp.merge_length,
                             i_rsp.caller_address});
                if (expected_ops.size() == 0) begin
                    o_failures++;
                    if (o_failures <= MAX_REPORTS)
                        $display("%0t: result with nothing expected: %s", $time, op_text(got));
                end else begin
                    want = expected_ops.pop_front();
                    if (got !== want) begin
                        o_failures++;
                        if (o_failures <= MAX_REPORTS) begin
                            $display("%0t: result mismatch", $time);
                            $display("  expected %s", op_text(want));
                            $display("  actual   %s", op_text(got));
                        end
                    end
                end
            end
            if (i_req.valid && i_req.ready) begin
                case (i_req.command)
                    CMD_READ, CMD_WRITE: begin
                        expected_ops.push_back(open_request(i_req.command == CMD_WRITE,
                                                            i_req.byte_position,
                                                            i_req.byte_count,
                                                            i_req.buffer_address));
                    end
                    CMD_DONE: begin
                        if (complete_step(i_req.storage_error, want))
                            expected_ops.push_back(want);
                    end
                    default: begin
                    end
                endcase
            end
        end
        o_pending = expected_ops.size();
    end

endmodule

// File: tb/sv/testbench.sv
// Top of the unaligned block request sequencer testbench: clock, reset, stimulus, verdict.
// Depends on ubrs_pkg, ubrs_if, the sequencer RTL and ubrs_op_monitor.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import ubrs_pkg::*;

    // Command code that the block must ignore
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    // Length of the long receiver hold-off, in cycles
    localparam int HOLD_CYCLES = 100;
    // Request items per random phase, about a third of the whole run
    localparam int PHASE_ITEMS = 570;
    // Cycles to linger once nothing is expected
    localparam int SETTLE_CYCLES = 20;

    logic i_clk = 1'b0;
    logic i_rst_n;

    int tx_idle_pct = 23;
    int rx_idle_pct = 63;
    bit hold_token  = 1'b0;
    bit hold_seen   = 1'b0;
    int hold_left   = 0;
    int items_sent  = 0;
    int pending_results;
    int fail_count;

    ubrs_req_if req_ch ();
    ubrs_rsp_if rsp_ch ();

    unaligned_block_request_sequencer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    ubrs_op_monitor op_monitor (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_ch),
        .i_rsp      (rsp_ch),
        .o_pending  (pending_results),
        .o_failures (fail_count)
    );

    always #4 i_clk = ~i_clk;

    // Receiver: a toggle of hold_token starts a long hold-off counted here;
    // otherwise drop ready at random according to the current idle share.
    always @(posedge i_clk) begin
        if (hold_token != hold_seen) begin
            hold_seen    <= hold_token;
            hold_left    <= HOLD_CYCLES;
            rsp_ch.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left    <= hold_left - 1;
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Offer one item and hold it until the block takes it. Valid stays high on
    // return, so a following item goes out back to back; the next call either
    // replaces the payload or drops valid, never both in one step.
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                             input logic [LEN_W-1:0] len, input logic [ADDR_W-1:0] addr,
                             input logic err);
        while ($urandom_range(99) < tx_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid          <= 1'b1;
        req_ch.command        <= cmd;
        req_ch.byte_position  <= pos;
        req_ch.byte_count     <= len;
        req_ch.buffer_address <= addr;
        req_ch.storage_error  <= err;
        do @(posedge i_clk); while (!req_ch.ready);
    endtask

    // Completion with junk in the fields the block should not look at
    task automatic send_completion(input logic err);
        send_item(CMD_DONE, POS_W'({$urandom, $urandom}), $urandom, $urandom, err);
    endtask

    // Stop offering and wait until every predicted result has been taken.
    // Sample the count on the falling edge, clear of the monitor's update.
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        do @(negedge i_clk); while (pending_results != 0);
        @(posedge i_clk);
    endtask

    // Number of storage operations a request splits into; sizes the run of
    // completions so that most sequences finish cleanly.
    function automatic int ops_needed(input logic is_wr, input logic [POS_W-1:0] pos,
                                      input logic [LEN_W-1:0] n);
        int unsigned      off, h;
        logic [LEN_W-1:0] whole;
        int               ops;
        ops = 0;
        if (n == 0) return 0;
        off = 32'(pos % BLOCK_BYTES);
        if (off != 0) begin
            h = BLOCK_BYTES - off;
            if (n < h) h = n;
            n = n - h;
            ops += is_wr ? 2 : 1;
        end
        whole = n - n % BLOCK_BYTES;
        ops += int'((64'(whole) + MAX_CHUNK - 1) / MAX_CHUNK);
        if (n != whole) ops += is_wr ? 2 : 1;
        return ops;
    endfunction

    // One whole request: the start, then a completion per operation. Now and
    // then slip in a start while busy or an unused code; abort_at > 0 fails
    // that completion and so drops the request.
    task automatic run_request(input logic is_wr, input logic [POS_W-1:0] pos,
                               input logic [LEN_W-1:0] n, input logic [ADDR_W-1:0] addr,
                               input int abort_at);
        int ops;
        ops = ops_needed(is_wr, pos, n);
        send_item(is_wr ? CMD_WRITE : CMD_READ, pos, n, addr, 1'($urandom_range(1)));
        items_sent++;
        for (int k = 1; k <= ops; k++) begin
            if ($urandom_range(99) < 3) begin
                send_item($urandom_range(1) ? CMD_WRITE : CMD_READ,
                          POS_W'({$urandom, $urandom}), $urandom, $urandom, 1'b0);
                items_sent++;
            end
            if ($urandom_range(99) < 2)
                send_item(CMD_UNUSED, POS_W'({$urandom, $urandom}), $urandom, $urandom,
                          1'($urandom_range(1)));
            if (k == abort_at) begin
                send_completion(1'b1);
                items_sent++;
                return;
            end
            send_completion(1'b0);
            items_sent++;
        end
    endtask

    // Random request: mostly short, some spanning several chunks, a few with
    // any 32-bit count, which have a storage error planned on an early completion.
    task automatic random_request();
        logic             is_wr;
        logic [POS_W-1:0] pos;
        logic [LEN_W-1:0] n;
        logic [ADDR_W-1:0] addr;
        int               pick, abort_at;
        is_wr = 1'($urandom_range(1));
        pos   = POS_W'({$urandom, $urandom});
        if ($urandom_range(99) < 30)
            pos[BLK_SHIFT-1:0] = '0;
        else if ($urandom_range(99) < 5)
            pos = {POS_W{1'b1}} - POS_W'($urandom_range(4095));
        addr = $urandom;
        if ($urandom_range(99) < 5)
            addr = {ADDR_W{1'b1}} - ADDR_W'($urandom_range(4095));
        pick     = $urandom_range(99);
        abort_at = 0;
        if (pick < 8) begin
            n = $urandom_range(16);
        end else if (pick < 55) begin
            n = $urandom_range(1, 1024);
        end else if (pick < 85) begin
            n = $urandom_range(1, 3 * MAX_CHUNK);
        end else if (pick < 95) begin
            n = $urandom_range(1, 20 * MAX_CHUNK);
        end else begin
            n = $urandom;
            abort_at = $urandom_range(1, 6);
        end
        if (abort_at == 0 && $urandom_range(99) < 6)
            abort_at = $urandom_range(1, 8);
        run_request(is_wr, pos, n, addr, abort_at);
    endtask

    initial begin
        int target;
        logic [POS_W-1:0] long_pos;

        req_ch.valid          = 1'b0;
        req_ch.command        = CMD_DONE;
        req_ch.byte_position  = '0;
        req_ch.byte_count     = '0;
        req_ch.buffer_address = '0;
        req_ch.storage_error  = 1'b0;
        i_rst_n               = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, under the first idling pattern.
        // Completions and the unused code while idle give nothing back.
        send_item(CMD_DONE, '0, '0, '0, 1'b0);
        send_item(CMD_DONE, '1, '1, '1, 1'b1);
        send_item(CMD_UNUSED, '1, '1, '1, 1'b1);
        // Empty requests finish at once, even from an unaligned position
        run_request(1'b0, 40'd5, '0, 32'h0000_0100, 0);
        run_request(1'b1, '1, '0, '1, 0);
        // Read that stays inside one block
        run_request(1'b0, 40'd100, 32'd50, 32'h0000_1000, 0);
        // Write with a one-byte head, a full and a one-block middle chunk, a tail
        run_request(1'b1, 40'd511, 1 + 17 * BLOCK_BYTES + 3, 32'h0000_2000, 0);
        // Aligned read of exactly one full chunk
        run_request(1'b0, 40'h200, MAX_CHUNK, 32'h0000_3000, 0);
        // Position and caller address both wrap round
        run_request(1'b1, 40'hFF_FFFF_FF00, 32'd1024, 32'hFFFF_FF80, 0);
        // Largest count; a second start is turned away, then a clean completion and a storage error
        send_item(CMD_READ, 40'h12_3456_7A01, '1, 32'h0, 1'b0);
        send_item(CMD_WRITE, '0, 32'd1, '1, 1'b0);
        send_completion(1'b0);
        send_completion(1'b1);
        wait_drained();

        // Random part in three idling patterns. In the first two, start with a
        // long hold-off on the receiver while a long write keeps coming, so the
        // block fills and stalls its input. Pause for a full drain after each.
        for (int phase = 0; phase < 3; phase++) begin
            if (phase == 1) begin
                tx_idle_pct  = 63;
                rx_idle_pct <= 23;
            end else if (phase == 2) begin
                tx_idle_pct  = 0;
                rx_idle_pct <= 0;
            end
            if (phase < 2) begin
                hold_token <= ~hold_token;
                long_pos = POS_W'({$urandom, $urandom});
                long_pos[BLK_SHIFT-1:0] = '0;
                run_request(1'b1, long_pos, 40 * BLOCK_BYTES + 7, $urandom, 0);
            end
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target) begin
                if ($urandom_range(99) < 5)
                    send_item($urandom_range(1) ? CMD_DONE : CMD_UNUSED,
                              POS_W'({$urandom, $urandom}), $urandom, $urandom,
                              1'($urandom_range(1)));
                random_request();
            end
            wait_drained();
        end

        // Linger so that any stray extra result is caught
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run
    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: files.f
src/ubrs_pkg.sv
src/ubrs_if.sv
src/ubrs_front.sv
src/ubrs_queue.sv
src/ubrs_back.sv
src/unaligned_block_request_sequencer.sv
tb/sv/ubrs_op_monitor.sv
tb/sv/testbench.sv
